/* hw/rtl/lzw_pkg.sv */
`timescale 1ns / 1ps

package lzw_pkg;

    // Fixed widths of the stream fields
    localparam int BYTE_W     = 8;
    localparam int OUT_W      = 12;
    // First code above the literal byte codes
    localparam int FIRST_FREE = 256;
    // Stream tag stored with each hash slot; tag 0 marks a cleared slot
    localparam int EPOCH_W    = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,   // sweeping the hash memory
        ST_IDLE,    // waiting for an input beat
        ST_CHECK    // read data of one hash slot is available
    } state_t;

    // One entry of the result queue
    typedef struct packed {
        logic [OUT_W-1:0] code;
        logic             is_last;
    } out_beat_t;

endpackage

/* hw/rtl/lzw_byte_encoder.sv */
`timescale 1ns / 1ps

// LZW byte encoder. Takes one byte per input beat (end_of_stream on the final
// byte) and gives the LZW codes of the stream, the last one flagged by
// final_code. Codes 0..255 are the literal bytes; learned strings get codes
// from 256 up to DICT_ENTRIES-1, after which the dictionary stays frozen until
// the stream ends; the next byte then starts a new stream with an empty
// dictionary. out_code carries the low 12 bits of a code. The dictionary is an
// open-addressed hash table in one single-port synchronous memory of
// 2*2^clog2(DICT_ENTRIES) slots, probed linearly. The first byte of a stream
// becomes the prefix (or the final code, if it ends the stream); every other
// byte is looked up by probing slots in turn, each probe being one read of
// the memory with a registered read. Up to two result beats are queued, so
// input keeps flowing while a result waits. After reset, and again after
// every 255 streams that learned at least one entry, the block sweeps the
// whole memory with in_ready low.
module lzw_byte_encoder
    import lzw_pkg::*;
#(
    parameter int DICT_ENTRIES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              end_of_stream,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  out_code,
    output logic              final_code
);

    localparam int CW   = $clog2(DICT_ENTRIES);  // code width
    localparam int NF_W = CW + 1;                // next free code, holds DICT_ENTRIES
    localparam int SW   = CW + 1;                // slot address width (load <= 1/2)

    localparam logic [NF_W-1:0]    DICT_LIM  = NF_W'(DICT_ENTRIES);
    localparam logic [NF_W-1:0]    NF_FIRST  = NF_W'(FIRST_FREE);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    // Hash slot: stream tag, key (prefix, byte), and the code of that string
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [CW-1:0]      prefix;
        logic [BYTE_W-1:0]  byte_val;
        logic [CW-1:0]      code;
    } slot_t;

    slot_t slot_mem [2**SW];

    state_t state_reg, state_next;

    logic [CW-1:0]      prefix_reg,       prefix_next;
    logic               prefix_valid_reg, prefix_valid_next;
    logic [NF_W-1:0]    nf_reg,           nf_next;
    logic [EPOCH_W-1:0] epoch_reg,        epoch_next;
    logic [SW-1:0]      probe_reg,        probe_next;
    logic [SW-1:0]      clr_reg,          clr_next;
    logic [BYTE_W-1:0]  byte_reg,         byte_next;
    logic               last_reg,         last_next;

    // Result queue: q0 is the head driven on the output port
    out_beat_t  q0_reg, q0_next;
    out_beat_t  q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;

    // Memory port
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    slot_t         rd_word_reg;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    slot_t         wr_data;

    logic          in_fire;
    logic          pop;
    logic          push_a, push_b;
    out_beat_t     beat_a, beat_b;

    logic          slot_live, slot_match;
    logic          hit, miss, probe_more;
    logic [2:0]    need;
    logic          can_finish;
    logic          do_finish;
    logic          go_clear;
    logic [SW-1:0] hash_addr;
    logic [CW-1:0] new_prefix;
    logic [NF_W-1:0] nf_after;

    // ------------------------------------------------------------------
    // Probe decode
    // ------------------------------------------------------------------
    assign in_fire    = in_valid && in_ready;
    assign pop        = out_valid && out_ready;

    // Slots tagged with another stream's epoch count as empty
    assign slot_live  = (rd_word_reg.epoch == epoch_reg);
    assign slot_match = (rd_word_reg.prefix == prefix_reg)
                     && (rd_word_reg.byte_val == byte_reg);
    assign hit        = slot_live && slot_match;
    assign miss       = !slot_live;
    assign probe_more = slot_live && !slot_match;

    // Result beats this byte produces; both must fit in the queue at once
    assign need       = {2'b00, miss} + {2'b00, last_reg};
    assign can_finish = ({1'b0, cnt_reg} + need) <= 3'd2;
    assign do_finish  = (state_reg == ST_CHECK) && !probe_more && can_finish;

    assign hash_addr  = {1'b0, prefix_reg}
                      ^ {data_byte, {(SW - BYTE_W){1'b0}}}
                      ^ SW'(data_byte);

    assign new_prefix = hit ? rd_word_reg.code : CW'(byte_reg);
    assign nf_after   = (miss && (nf_reg < DICT_LIM)) ? nf_reg + NF_W'(1) : nf_reg;

    // A stream that learned something retires its epoch; wrap forces a sweep
    assign go_clear   = do_finish && last_reg && (nf_after != NF_FIRST)
                     && (epoch_reg == EPOCH_MAX);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && prefix_valid_reg)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (go_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else if (do_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready          = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = probe_reg;
        wr_en             = 1'b0;
        wr_addr           = probe_reg;
        wr_data           = '0;
        push_a            = 1'b0;
        push_b            = 1'b0;
        beat_a            = '0;
        beat_b            = '0;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        nf_next           = nf_reg;
        epoch_next        = epoch_reg;
        probe_next        = probe_reg;
        clr_next          = clr_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + SW'(1);
            end
            ST_IDLE:
            begin
                // Room for one beat covers the single-byte stream case
                in_ready = (cnt_reg != 2'd2);
                if (in_fire)
                begin
                    if (!prefix_valid_reg)
                    begin
                        // First byte of a stream becomes the prefix, or the final code if it ends the stream
                        if (end_of_stream)
                        begin
                            push_b         = 1'b1;
                            beat_b.code    = OUT_W'(data_byte);
                            beat_b.is_last = 1'b1;
                            prefix_next    = '0;
                        end
                        else
                        begin
                            prefix_next       = CW'(data_byte);
                            prefix_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = hash_addr;
                        probe_next = hash_addr;
                        byte_next  = data_byte;
                        last_next  = end_of_stream;
                    end
                end
            end
            ST_CHECK:
            begin
                if (probe_more)
                begin
                    // Occupied by another string: linear probe
                    rd_en      = 1'b1;
                    rd_addr    = probe_reg + SW'(1);
                    probe_next = probe_reg + SW'(1);
                end
                else if (can_finish)
                begin
                    if (miss)
                    begin
                        push_a         = 1'b1;
                        beat_a.code    = OUT_W'(prefix_reg);
                        beat_a.is_last = 1'b0;
                        if (nf_reg < DICT_LIM)
                        begin
                            wr_en            = 1'b1;
                            wr_data.epoch    = epoch_reg;
                            wr_data.prefix   = prefix_reg;
                            wr_data.byte_val = byte_reg;
                            wr_data.code     = CW'(nf_reg);
                        end
                    end
                    nf_next     = nf_after;
                    prefix_next = new_prefix;
                    if (last_reg)
                    begin
                        push_b            = 1'b1;
                        beat_b.code       = OUT_W'(new_prefix);
                        beat_b.is_last    = 1'b1;
                        prefix_next       = '0;
                        prefix_valid_next = 1'b0;
                        nf_next           = NF_FIRST;
                        if (nf_after != NF_FIRST)
                        begin
                            epoch_next = (epoch_reg == EPOCH_MAX) ? EPOCH_ONE
                                                                  : epoch_reg + EPOCH_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result queue: pop first, then append in order a, b
    // ------------------------------------------------------------------
    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        if (push_a)
        begin
            if (cnt_next == 2'd0)
            begin
                q0_next = beat_a;
            end
            else
            begin
                q1_next = beat_a;
            end
            cnt_next = cnt_next + 2'd1;
        end
        if (push_b)
        begin
            if (cnt_next == 2'd0)
            begin
                q0_next = beat_b;
            end
            else
            begin
                q1_next = beat_b;
            end
            cnt_next = cnt_next + 2'd1;
        end
    end

    assign out_valid  = (cnt_reg != 2'd0);
    assign out_code   = q0_reg.code;
    assign final_code = q0_reg.is_last;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            nf_reg           <= NF_FIRST;
            epoch_reg        <= EPOCH_ONE;
            clr_reg          <= '0;
            cnt_reg          <= 2'd0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            nf_reg           <= nf_next;
            epoch_reg        <= epoch_next;
            clr_reg          <= clr_next;
            cnt_reg          <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
    end

    // Hash memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= slot_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("memory read and write in one cycle");

    a_prefix_known: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_valid_reg |-> ({1'b0, prefix_reg} < nf_reg))
        else $error("prefix refers to an unassigned code");

    a_learn_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == ST_CHECK)) |-> (nf_reg < DICT_LIM))
        else $error("dictionary write past its size");

    a_check_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CHECK) && $past(state_reg == ST_IDLE))
            |-> $past(in_fire && prefix_valid_reg))
        else $error("probe started without an accepted byte");

endmodule
